// ===== src/gif_lzw_pixel_decoder_core_assert.svh =====
// Assertion macros for the GIF LZW pixel decoder.
`ifndef GIF_LZW_PIXEL_DECODER_CORE_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GLD_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define GLD_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GLD_ASSERT_IMP(label, clk, rst_n, a, c)
`define GLD_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/gld_pkg.sv =====
// Package of types and constants for the GIF LZW pixel decoder.
package gld_pkg;
  localparam int TableEntriesDef = 4096;
  localparam int MaxCodeBitsDef = 12;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_PULL = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_DECODING = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE, PH_LEN, PH_DATA, PH_ENDED, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_DECODE, FS_WALK, FS_WAITPOP, FS_OUT
  } fsm_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       pixel_valid;
    logic [7:0] pixel;
    logic       need_data;
    logic [1:0] status;
  } out_item_t;
endpackage

// ===== src/gld_dict.sv =====
// Dictionary memory: prefix and suffix stores with registered read.
module gld_dict import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [MAX_CODE_BITS-1:0]       wprefix,
  input  logic [7:0]                     wsuffix,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [MAX_CODE_BITS-1:0]       rprefix,
  output logic [7:0]                     rsuffix
);
  logic [MAX_CODE_BITS-1:0] prefix_mem [TABLE_ENTRIES];
  logic [7:0] suffix_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      prefix_mem[waddr] <= wprefix;
      suffix_mem[waddr] <= wsuffix;
    end
    rprefix <= prefix_mem[raddr];
    rsuffix <= suffix_mem[raddr];
  end
endmodule

// ===== src/gld_stack.sv =====
// String stack memory with registered read.
module gld_stack import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [7:0]                       wdata,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [7:0]                       rdata
);
  logic [7:0] stack_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) stack_mem[waddr] <= wdata;
    rdata <= stack_mem[raddr];
  end
endmodule

// ===== src/gif_lzw_pixel_decoder_core.sv =====
// Top level of the GIF LZW pixel decoder.
// Usage: items arrive on in_valid/in_stall carrying a request type and a
// byte. Push items feed the raw stream (code size byte, sub-block lengths,
// data). Pull items return one pixel index. Restart items re-arm decoding.
// Every item gives exactly one result item on out_valid/out_stall.
// Sequencing: a push, restart or unknown item has its result registered at
// the edge that accepts it. A pull that pops an already stacked pixel
// passes through the decode, pop-wait and output states in that order. A
// pull that has to decode takes one code per visit to the decode state; a
// code that extends the table then walks its prefix chain in the walk
// state through the dictionary read port, one entry per cycle, before the
// stack read as above.
// A new item is accepted while no pull is being decoded and the result
// register is empty or is being taken; when the receiver stalls, the result
// holds and in_stall rises.
// Reset (rst_n low, synchronous) returns the decoder to expect the code
// size byte and sets the pixel limit to one; no clearing pass is needed,
// the memories are only read at entries that decoding has written.
// cfg_we writes the pixel limit; write it only while the block is idle.
module gif_lzw_pixel_decoder_core import gld_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int MAX_CODE_BITS = MaxCodeBitsDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata
);
`include "gif_lzw_pixel_decoder_core_assert.svh"
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam int WW = $clog2(MAX_CODE_BITS + 1);
  localparam logic [CW-1:0] ENTRIES = CW'(TABLE_ENTRIES);

  fsm_t fs_r, fs_nxt;
  phase_t ph_r, ph_nxt;
  logic [31:0] limit_r, limit_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0] bc_r, bc_nxt;
  logic [WW-1:0] cwid_r, cwid_nxt;
  logic [CW-1:0] nidx_r, nidx_nxt;
  logic [MAX_CODE_BITS-1:0] prev_r, prev_nxt;
  logic [7:0] fop_r, fop_nxt;
  logic [3:0] root_r, root_nxt;
  logic [7:0] sbl_r, sbl_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic hp_r, hp_nxt;
  logic [MAX_CODE_BITS-1:0] code_r, code_nxt;
  logic [CW-1:0] walk_r, walk_nxt;
  logic need_r, need_nxt;
  logic ov_r, ov_nxt;
  out_item_t od_r, od_nxt;
  logic popped_r;

  logic d_we;
  logic [AW-1:0] d_waddr, d_raddr;
  logic [MAX_CODE_BITS-1:0] d_wprefix, d_rprefix;
  logic [7:0] d_wsuffix, d_rsuffix;
  logic s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [7:0] s_wdata, s_rdata;

  gld_dict #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dict (
    .clk, .we(d_we), .waddr(d_waddr), .wprefix(d_wprefix), .wsuffix(d_wsuffix),
    .raddr(d_raddr), .rprefix(d_rprefix), .rsuffix(d_rsuffix));
  gld_stack #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr),
    .rdata(s_rdata));

  logic out_free, in_acc;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (fs_r != FS_IDLE) || !out_free;
  assign in_acc = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data = od_r;

  logic [CW-1:0] clear_c, eoi_c;
  logic [MAX_CODE_BITS-1:0] cur_code;
  logic [1:0] stat_c;
  assign clear_c = CW'(1) << root_r;
  assign eoi_c = clear_c + CW'(1);
  assign cur_code = MAX_CODE_BITS'(acc_r & ((32'd1 << cwid_r) - 32'd1));
  assign stat_c = (ph_r == PH_ERROR) ? ST_ERROR : (ph_r == PH_DONE) ? ST_DONE : ST_DECODING;

  // Next state of the sequencer.
  always_comb begin
    fs_nxt = fs_r;
    case (fs_r)
      FS_IDLE: if (in_acc && in_data.req_type == REQ_PULL) fs_nxt = FS_DECODE;
      FS_DECODE: begin
        if (sc_r != '0 && ph_r != PH_ERROR) fs_nxt = FS_WAITPOP;
        else if (sc_r != '0 || ph_r == PH_DONE || ph_r == PH_ERROR || ph_r == PH_SIZE ||
                 bc_r < 6'(cwid_r)) fs_nxt = FS_OUT;
        else if (hp_r && CW'(cur_code) != clear_c && CW'(cur_code) != eoi_c &&
                 !(CW'(cur_code) > nidx_r || nidx_r >= ENTRIES)) fs_nxt = FS_WALK;
      end
      FS_WALK: if (!(walk_r > eoi_c && walk_r < ENTRIES && sc_r < ENTRIES)) fs_nxt = FS_DECODE;
      FS_WAITPOP: fs_nxt = FS_OUT;
      FS_OUT: if (out_free) fs_nxt = FS_IDLE;
      default: fs_nxt = FS_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ph_nxt = ph_r; limit_nxt = limit_r; sc_nxt = sc_r; acc_nxt = acc_r; bc_nxt = bc_r;
    cwid_nxt = cwid_r; nidx_nxt = nidx_r; prev_nxt = prev_r; fop_nxt = fop_r;
    root_nxt = root_r; sbl_nxt = sbl_r; pix_nxt = pix_r; hp_nxt = hp_r;
    code_nxt = code_r; walk_nxt = walk_r; need_nxt = need_r;
    ov_nxt = ov_r && out_stall; od_nxt = od_r;
    d_we = 1'b0; d_waddr = AW'(nidx_r); d_wprefix = prev_r; d_wsuffix = walk_r[7:0];
    d_raddr = AW'(walk_r); s_we = 1'b0; s_waddr = AW'(sc_r); s_wdata = '0;
    s_raddr = AW'(sc_r - CW'(1));
    if (cfg_we) limit_nxt = cfg_wdata;
    case (fs_r)
      FS_IDLE: if (in_acc) begin
        od_nxt = '0;
        need_nxt = 1'b0;
        case (in_data.req_type)
          REQ_PUSH: begin
            od_nxt.accepted = 1'b1;
            case (ph_r)
              PH_SIZE: begin
                if (in_data.data_byte < 8'd1 || in_data.data_byte > 8'd8) begin
                  ph_nxt = PH_ERROR; sc_nxt = '0;
                end else begin
                  root_nxt = in_data.data_byte[3:0];
                  cwid_nxt = WW'(in_data.data_byte) + WW'(1);
                  nidx_nxt = (CW'(1) << in_data.data_byte[3:0]) + CW'(2);
                  hp_nxt = 1'b0; ph_nxt = PH_LEN;
                end
              end
              PH_LEN: begin
                if (in_data.data_byte == 8'd0) ph_nxt = PH_ENDED;
                else begin sbl_nxt = in_data.data_byte; ph_nxt = PH_DATA; end
              end
              PH_DATA: begin
                if (bc_r > 6'd24) od_nxt.accepted = 1'b0;
                else begin
                  acc_nxt = acc_r | (32'(in_data.data_byte) << bc_r);
                  bc_nxt = bc_r + 6'd8;
                  sbl_nxt = sbl_r - 8'd1;
                  if (sbl_r == 8'd1) ph_nxt = PH_LEN;
                end
              end
              default: ;
            endcase
            od_nxt.status = (ph_nxt == PH_ERROR) ? ST_ERROR :
                            (ph_nxt == PH_DONE) ? ST_DONE : ST_DECODING;
            ov_nxt = 1'b1;
          end
          REQ_RESTART: begin
            sc_nxt = '0; acc_nxt = '0; bc_nxt = '0; cwid_nxt = '0; nidx_nxt = '0;
            prev_nxt = '0; fop_nxt = '0; root_nxt = '0; sbl_nxt = '0;
            ph_nxt = PH_SIZE; pix_nxt = '0; hp_nxt = 1'b0;
            od_nxt.status = ST_DECODING; ov_nxt = 1'b1;
          end
          REQ_PULL: ;
          default: begin od_nxt.status = stat_c; ov_nxt = 1'b1; end
        endcase
      end
      FS_DECODE: begin
        if (sc_r == '0 && ph_r != PH_DONE && ph_r != PH_ERROR) begin
          if (ph_r == PH_SIZE) need_nxt = 1'b1;
          else if (bc_r < 6'(cwid_r)) begin
            if (ph_r == PH_ENDED) ph_nxt = PH_DONE; else need_nxt = 1'b1;
          end else begin
            acc_nxt = acc_r >> cwid_r;
            bc_nxt = bc_r - 6'(cwid_r);
            code_nxt = cur_code;
            if (CW'(cur_code) == clear_c) begin
              cwid_nxt = WW'(root_r) + WW'(1); nidx_nxt = clear_c + CW'(2); hp_nxt = 1'b0;
            end else if (!hp_r) begin
              if (CW'(cur_code) > clear_c) begin ph_nxt = PH_ERROR; sc_nxt = '0; end
              else begin
                // A root code is a one-pixel string.
                s_we = 1'b1; s_wdata = cur_code[7:0]; sc_nxt = sc_r + CW'(1);
                if ({1'b0, pix_r} + 33'd1 > {1'b0, limit_r}) begin
                  ph_nxt = PH_ERROR; sc_nxt = '0;
                end else begin
                  pix_nxt = pix_r + 32'd1; prev_nxt = cur_code; fop_nxt = cur_code[7:0];
                  hp_nxt = 1'b1;
                end
              end
            end else if (CW'(cur_code) == eoi_c) ph_nxt = PH_DONE;
            else if (CW'(cur_code) > nidx_r || nidx_r >= ENTRIES) begin
              ph_nxt = PH_ERROR; sc_nxt = '0;
            end else if (CW'(cur_code) == nidx_r) begin
              s_we = 1'b1; s_wdata = fop_r; sc_nxt = sc_r + CW'(1);
              walk_nxt = CW'(prev_r); d_raddr = AW'(prev_r);
            end else begin
              walk_nxt = CW'(cur_code); d_raddr = AW'(cur_code);
            end
          end
        end
      end
      FS_WALK: begin
        if (walk_r > eoi_c && walk_r < ENTRIES && sc_r < ENTRIES) begin
          s_we = 1'b1; s_wdata = d_rsuffix; sc_nxt = sc_r + CW'(1);
          walk_nxt = CW'(d_rprefix); d_raddr = AW'(d_rprefix);
        end else begin
          // Chain ends at a root: push it, count pixels and, if the limit holds, extend the table.
          if (sc_r < ENTRIES) begin
            s_we = 1'b1; s_wdata = walk_r[7:0]; sc_nxt = sc_r + CW'(1);
          end
          if ({1'b0, pix_r} + 33'(sc_nxt) > {1'b0, limit_r}) begin
            ph_nxt = PH_ERROR; sc_nxt = '0;
          end else begin
            pix_nxt = pix_r + 32'(sc_nxt);
            d_we = 1'b1;
            nidx_nxt = nidx_r + CW'(1);
            fop_nxt = walk_r[7:0];
            prev_nxt = code_r;
            if (nidx_nxt == (CW'(1) << cwid_r) && cwid_r < WW'(MAX_CODE_BITS))
              cwid_nxt = cwid_r + WW'(1);
          end
        end
      end
      FS_WAITPOP: sc_nxt = sc_r - CW'(1);
      FS_OUT: if (out_free) begin
        od_nxt = '0;
        od_nxt.need_data = need_r;
        od_nxt.status = stat_c;
        if (popped_r) begin
          od_nxt.pixel_valid = 1'b1;
          od_nxt.pixel = s_rdata;
        end
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_IDLE; ph_r <= PH_SIZE; limit_r <= 32'd1; sc_r <= '0; acc_r <= '0;
      bc_r <= '0; cwid_r <= '0; nidx_r <= '0; prev_r <= '0; fop_r <= '0; root_r <= '0;
      sbl_r <= '0; pix_r <= '0; hp_r <= 1'b0; ov_r <= 1'b0; need_r <= 1'b0;
      popped_r <= 1'b0;
    end else begin
      fs_r <= fs_nxt; ph_r <= ph_nxt; limit_r <= limit_nxt; sc_r <= sc_nxt; acc_r <= acc_nxt;
      bc_r <= bc_nxt; cwid_r <= cwid_nxt; nidx_r <= nidx_nxt; prev_r <= prev_nxt;
      fop_r <= fop_nxt; root_r <= root_nxt; sbl_r <= sbl_nxt; pix_r <= pix_nxt;
      hp_r <= hp_nxt; ov_r <= ov_nxt; need_r <= need_nxt;
      popped_r <= (fs_r == FS_WAITPOP) ? 1'b1 : (fs_r == FS_OUT && out_free) ? 1'b0 : popped_r;
    end
  end
  always_ff @(posedge clk) begin
    code_r <= code_nxt; walk_r <= walk_nxt;
    od_r <= od_nxt;
  end

  `GLD_ASSERT_IMP(a_in_busy, clk, rst_n, fs_r != FS_IDLE, in_stall)
  `GLD_ASSERT_NXT(a_pop_out, clk, rst_n, fs_r == FS_WAITPOP, fs_r == FS_OUT)
  `GLD_ASSERT_IMP(a_err_empty, clk, rst_n, ph_r == PH_ERROR && fs_r == FS_IDLE, sc_r == '0)
endmodule

// ===== tb/tb_gif_lzw_pixel_decoder_core.sv =====
// Self-checking testbench for the GIF LZW pixel decoder core.
`timescale 1ns / 100ps

module tb_gif_lzw_pixel_decoder_core;
  import gld_pkg::*;

  localparam int WatchLimit = 200000;

  class lzw_scoreboard;
    logic [31:0] pix_limit;
    logic [11:0] prefix_mem [4096];
    logic [7:0]  suffix_mem [4096];
    logic [7:0]  stack_mem [4096];
    int unsigned stk_n, acc, nbits, cwidth, next_idx, prev_code, first_prev;
    int unsigned root, left, pix_out;
    phase_t      ph;
    bit          have_prev;
    out_item_t   pending[$];
    int          errors;

    function new();
      pix_limit = 1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      stk_n = 0; acc = 0; nbits = 0; cwidth = 0; next_idx = 0; prev_code = 0;
      first_prev = 0; root = 0; left = 0; pix_out = 0; ph = PH_SIZE;
      have_prev = 0;
    endfunction

    function void push_pix(int unsigned v);
      if (stk_n < 4096) begin
        stack_mem[stk_n] = v[7:0];
        stk_n++;
      end
    endfunction

    function void fail_state();
      ph = PH_ERROR;
      stk_n = 0;
    endfunction

    function bit tally();
      if (longint'(pix_out) + stk_n > longint'(pix_limit)) begin
        fail_state();
        return 0;
      end
      pix_out += stk_n;
      return 1;
    endfunction

    function void decode(int unsigned code);
      int unsigned clr, eoi, c;
      clr = 1 << root;
      eoi = clr + 1;
      if (code == clr) begin
        cwidth = root + 1;
        next_idx = clr + 2;
        have_prev = 0;
        return;
      end
      if (!have_prev) begin
        if (code > clr) begin
          fail_state();
          return;
        end
        push_pix(code);
        if (!tally()) return;
        prev_code = code;
        first_prev = code;
        have_prev = 1;
        return;
      end
      if (code == eoi) begin
        ph = PH_DONE;
        return;
      end
      if (code > next_idx || next_idx >= 4096) begin
        fail_state();
        return;
      end
      if (code == next_idx) begin
        push_pix(first_prev);
        c = prev_code;
      end else begin
        c = code;
      end
      while (c > eoi && c < 4096 && stk_n < 4096) begin
        push_pix(suffix_mem[c]);
        c = prefix_mem[c];
      end
      push_pix(c);
      if (!tally()) return;
      prefix_mem[next_idx] = prev_code[11:0];
      suffix_mem[next_idx] = c[7:0];
      next_idx++;
      first_prev = c & 8'hff;
      prev_code = code;
      if (next_idx == (1 << cwidth) && cwidth < 12) cwidth++;
    endfunction

    function bit push_byte(int unsigned b);
      case (ph)
        PH_SIZE: begin
          if (b < 1 || b > 8) begin
            fail_state();
            return 1;
          end
          root = b;
          cwidth = b + 1;
          next_idx = (1 << b) + 2;
          have_prev = 0;
          ph = PH_LEN;
        end
        PH_LEN: begin
          if (b == 0) ph = PH_ENDED;
          else begin
            left = b;
            ph = PH_DATA;
          end
        end
        PH_DATA: begin
          if (nbits > 24) return 0;
          acc |= b << nbits;
          nbits += 8;
          left--;
          if (left == 0) ph = PH_LEN;
        end
        default: ;
      endcase
      return 1;
    endfunction

    // Works out the result of one accepted input item.
    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned code;
      r = '0;
      if (it.req_type == REQ_PUSH) begin
        r.accepted = push_byte(it.data_byte);
      end else if (it.req_type == REQ_RESTART) begin
        restart();
      end else if (it.req_type == REQ_PULL) begin
        while (stk_n == 0 && ph < PH_DONE) begin
          if (ph == PH_SIZE) begin
            r.need_data = 1;
            break;
          end
          if (nbits < cwidth) begin
            if (ph == PH_ENDED) ph = PH_DONE;
            else r.need_data = 1;
            break;
          end
          code = acc & ((1 << cwidth) - 1);
          acc >>= cwidth;
          nbits -= cwidth;
          decode(code);
        end
        if (stk_n > 0 && ph != PH_ERROR) begin
          stk_n--;
          r.pixel = stack_mem[stk_n];
          r.pixel_valid = 1;
        end
      end
      r.status = (ph == PH_ERROR) ? ST_ERROR : (ph == PH_DONE) ? ST_DONE : ST_DECODING;
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
      if (got.pixel_valid !== want.pixel_valid)
        report("pixel_valid", got.pixel_valid, want.pixel_valid);
      if (got.pixel !== want.pixel) report("pixel", got.pixel, want.pixel);
      if (got.need_data !== want.need_data) report("need_data", got.need_data, want.need_data);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, cfg_we = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic [31:0] cfg_wdata = '0;
  lzw_scoreboard sb;
  bit quiet = 0;
  int idle_cnt = 0;

  gif_lzw_pixel_decoder_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic send(logic [1:0] rt, logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{req_type: rt, data_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_limit(logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.pix_limit = v;
  endtask

  // Builds a stream of random codes, well-formed unless broken is set, pushing it with pulls mixed in.
  task automatic run_stream(int npix, bit broken);
    int unsigned root, cw, nxt, code, bits, nb, sub_left;
    logic [7:0] bytes[$];
    bit first;
    root = $urandom_range(1, 8);
    cw = root + 1;
    nxt = (1 << root) + 2;
    bits = 0; nb = 0; first = 1;
    for (int i = 0; i < npix; i++) begin
      if (!first && $urandom_range(0, 30) == 0) begin
        code = 1 << root;
        first = 1;
      end else if (first) begin
        code = $urandom_range(0, (1 << root) - 1);
      end else begin
        code = $urandom_range(0, 3) == 0 ? nxt : $urandom_range(0, (1 << root) - 1);
        if ($urandom_range(0, 1) && nxt > (1 << root) + 2)
          code = $urandom_range((1 << root) + 2, nxt);
        if (broken && $urandom_range(0, 15) == 0) code = $urandom_range(0, (1 << cw) - 1);
      end
      bits |= code << nb;
      nb += cw;
      if (code == (1 << root)) begin
        cw = root + 1;
        nxt = (1 << root) + 2;
      end else begin
        // The first code after a clear adds no table entry.
        if (!first && nxt < 4096) begin
          nxt++;
          if (nxt == (1 << cw) && cw < 12) cw++;
        end
        first = 0;
      end
      while (nb >= 8) begin
        bytes.push_back(bits[7:0]);
        bits >>= 8;
        nb -= 8;
      end
    end
    bits |= ((1 << root) + 1) << nb;
    nb += cw;
    while (nb > 0) begin
      bytes.push_back(bits[7:0]);
      bits >>= 8;
      nb = nb > 8 ? nb - 8 : 0;
    end
    send(REQ_RESTART, 8'($urandom));
    send(REQ_PUSH, 8'(root));
    while (bytes.size() > 0) begin
      sub_left = $urandom_range(1, bytes.size() < 255 ? bytes.size() : 255);
      send(REQ_PUSH, 8'(sub_left));
      repeat (sub_left) begin
        send(REQ_PUSH, bytes.pop_front());
        if ($urandom_range(0, 2) == 0) send(REQ_PULL, 8'($urandom));
      end
    end
    send(REQ_PUSH, 8'd0);
    repeat ($urandom_range(2, 12)) send(REQ_PULL, 8'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: pull before the code size, bad sizes, unknown type.
    send(REQ_PULL, 8'h00);
    send(REQ_PUSH, 8'h00);
    send(REQ_PULL, 8'hff);
    send(REQ_PUSH, 8'hff);
    send(REQ_UNUSED, 8'h55);
    send(REQ_RESTART, 8'h00);
    send(REQ_PUSH, 8'd9);
    send(REQ_RESTART, 8'h00);
    // Size 2, one block: clear, 1, 6 (kwkwk), eoi, with pixel limit one.
    send(REQ_PUSH, 8'd2);
    send(REQ_PUSH, 8'd2);
    send(REQ_PUSH, 8'h8c);
    send(REQ_PUSH, 8'h0b);
    send(REQ_PUSH, 8'h00);
    send(REQ_PULL, 8'h00);
    send(REQ_PULL, 8'h00);
    send(REQ_PUSH, 8'haa);
    set_limit(32'hffff_ffff);
    // First code above clear, then full buffer pressure.
    send(REQ_RESTART, 8'h00);
    send(REQ_PUSH, 8'd1);
    send(REQ_PUSH, 8'd6);
    repeat (5) send(REQ_PUSH, 8'hff);
    send(REQ_PULL, 8'h00);
    send(REQ_PULL, 8'h00);
    set_limit(32'd40);
    run_stream(60, 0);
    set_limit(32'hffff_ffff);
    for (int k = 0; k < 20; k++) begin
      if (k == 16) quiet = 1;
      if (k % 4 == 3) set_limit($urandom_range(1, 80));
      else if (k % 4 == 0) set_limit(32'hffff_ffff);
      run_stream($urandom_range(5, 50), k % 3 == 2);
      repeat (3) send(2'($urandom_range(0, 3)), 8'($urandom));
    end
    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
